/* design/bst_pkg.sv */
// shared types, codes and character constants of the build script tokenizer
package bst_pkg;

  // token kinds
  localparam logic [2:0] KIND_COMMAND  = 3'd0;
  localparam logic [2:0] KIND_VARIABLE = 3'd1;
  localparam logic [2:0] KIND_FUNCTION = 3'd2;
  localparam logic [2:0] KIND_CALL     = 3'd3;
  localparam logic [2:0] KIND_STRING   = 3'd4;
  localparam logic [2:0] KIND_COMMENT  = 3'd5;
  localparam logic [2:0] KIND_UNSET    = 3'd7;

  // result event kinds
  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  // syntax error codes
  localparam logic [2:0] ERR_ESCAPE = 3'd0;
  localparam logic [2:0] ERR_HASH   = 3'd1;
  localparam logic [2:0] ERR_EQUALS = 3'd2;
  localparam logic [2:0] ERR_COLON  = 3'd3;
  localparam logic [2:0] ERR_BANG   = 3'd4;

  // characters that steer the lexer
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // what one input byte does to the lexer state
  typedef struct packed {
    logic       append;
    logic       close;
    logic [2:0] close_kind;
    logic       error;
    logic [2:0] err_code;
    logic [2:0] kind_next;
    logic       esc_next;
    logic       line_inc;
  } step_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

/* design/bst_step.sv */
// byte decoder: lexing rules for one text byte against the current token state
module bst_step
  import bst_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic [2:0] kind_i,
  input  logic       esc_i,
  input  logic       len_nz_i,
  output step_t      step_o
);

  logic text;
  logic unset;

  assign text  = (kind_i == KIND_STRING) || (kind_i == KIND_COMMENT);
  assign unset = (kind_i == KIND_UNSET);

  always_comb begin
    step_o            = '0;
    step_o.err_code   = ERR_ESCAPE;
    step_o.kind_next  = kind_i;
    step_o.esc_next   = esc_i;
    step_o.close_kind = unset ? KIND_COMMAND : kind_i;
    case (byte_i)
      CH_BSLASH: begin
        if (!esc_i) begin
          step_o.esc_next = 1'b1;
        end else if (!unset) begin
          step_o.append   = 1'b1;
          step_o.esc_next = 1'b0;
        end else begin
          step_o.error = 1'b1;
        end
      end
      CH_HASH: begin
        if (!esc_i && unset) begin
          step_o.close     = len_nz_i;
          step_o.kind_next = KIND_COMMENT;
        end else if (text) begin
          step_o.esc_next = 1'b0;
          step_o.append   = 1'b1;
        end else begin
          step_o.esc_next = 1'b0;
          step_o.error    = 1'b1;
          step_o.err_code = ERR_HASH;
        end
      end
      CH_QUOTE: begin
        if (unset) begin
          if (!esc_i) begin
            step_o.kind_next = KIND_STRING;
          end else begin
            step_o.error = 1'b1;
          end
        end else if (kind_i == KIND_STRING) begin
          if (esc_i) begin
            step_o.append   = 1'b1;
            step_o.esc_next = 1'b0;
          end else begin
            step_o.close     = 1'b1;
            step_o.kind_next = KIND_UNSET;
          end
        end
      end
      CH_EQUALS, CH_COLON: begin
        if (unset) begin
          if (esc_i) begin
            step_o.error    = 1'b1;
            step_o.esc_next = 1'b0;
          end else begin
            step_o.close      = 1'b1;
            step_o.close_kind = (byte_i == CH_EQUALS) ? KIND_VARIABLE : KIND_FUNCTION;
            step_o.kind_next  = KIND_UNSET;
          end
        end else if (text) begin
          step_o.append = 1'b1;
        end else begin
          step_o.error    = 1'b1;
          step_o.err_code = (byte_i == CH_EQUALS) ? ERR_EQUALS : ERR_COLON;
        end
      end
      CH_BANG: begin
        if (text) begin
          step_o.append = 1'b1;
        end else if (!unset) begin
          step_o.error    = 1'b1;
          step_o.err_code = ERR_BANG;
        end else begin
          step_o.kind_next = KIND_CALL;
        end
      end
      CH_SPACE, CH_TAB: begin
        if (!text && !unset) begin
          step_o.close     = 1'b1;
          step_o.kind_next = KIND_UNSET;
        end else begin
          step_o.append = 1'b1;
        end
      end
      CH_NL: begin
        if (esc_i) begin
          step_o.esc_next = 1'b0;
        end else begin
          step_o.close     = 1'b1;
          step_o.kind_next = KIND_UNSET;
        end
        step_o.line_inc = 1'b1;
      end
      default: begin
        step_o.append = 1'b1;
      end
    endcase
  end

endmodule

/* design/build_script_tokenizer.sv */
// top level of the build script tokenizer: token store, trim tracking and result output
// Build script tokenizer. Takes one raw text byte per request on the input channel and
// gives results on the output channel: one result per byte of a closed token with leading
// and trailing blanks trimmed, one empty-token result for a token that trims to nothing,
// or one syntax-error result. The last result caused by a byte carries last_of_token.
// Token bytes sit in a TOKEN_MAX deep single-port-write, single-read memory with a
// registered read. An ordinary byte and one that only changes state do not wait on the
// output; one that gives an error or empty-token result is held off while the output
// register is full and stalled. A byte that closes a token with bytes left after
// trimming streams them from the memory one entry a cycle while the output is not
// stalled, and no new byte is taken meanwhile. The trim bounds are tracked while bytes
// are appended, so no search happens at close. Bytes past TOKEN_MAX are dropped and the
// token reports overflowed. A write on the cfg channel loads the line counter and holds
// off the byte input in that cycle; it is meant only while the block is idle and
// cfg_ready_o is always high. Reset puts the line counter at 1.
module build_script_tokenizer
  import bst_pkg::*;
#(
  parameter int TOKEN_MAX = 64,
  parameter int LINE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_wdata_i,
  // text byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  token_byte_o,
  output logic [15:0] line_number_o,
  output logic [2:0]  error_code_o,
  output logic        overflowed_o,
  output logic        last_of_token_o
);

  localparam int AW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
  localparam int LW = $clog2(TOKEN_MAX + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(TOKEN_MAX);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  // lexer state
  state_e         state_q, state_d;
  logic [2:0]     kind_q, kind_d;
  logic           esc_q, esc_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [LW-1:0]  len_q, len_d;
  logic           ovf_q, ovf_d;
  // trim bounds: first non-blank index and one past the last non-blank
  logic           nb_seen_q, nb_seen_d;
  logic [LW-1:0]  first_q, first_d;
  logic [LW-1:0]  hi_q, hi_d;

  // token readout
  logic [LW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]  end_q, end_d;
  logic           rd_more_q, rd_more_d;
  logic           dat_vld_q, dat_vld_d;
  logic           dat_last_q, dat_last_d;
  logic [2:0]     emit_kind_q, emit_kind_d;
  logic [15:0]    emit_line_q, emit_line_d;
  logic           emit_ovf_q, emit_ovf_d;

  // output register
  logic           out_valid_q, out_valid_d;
  logic [1:0]     out_event_q, out_event_d;
  logic [2:0]     out_kind_q, out_kind_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic [15:0]    out_line_q, out_line_d;
  logic [2:0]     out_code_q, out_code_d;
  logic           out_ovf_q, out_ovf_d;
  logic           out_last_q, out_last_d;

  // token store
  logic [7:0]     mem [TOKEN_MAX];
  logic [7:0]     rd_data_q;
  logic           wr_en;
  logic           rd_en;

  step_t          step;
  logic           cfg_wr;
  logic           in_acc;
  logic           direct;
  logic           out_free;
  logic           out_load;
  logic           rd_last;
  logic [15:0]    line16;
  logic [LINE_BITS+15:0] line_ext;
  logic [LINE_BITS+15:0] cfg_ext;

  bst_step u_step (
    .byte_i   (text_byte_i),
    .kind_i   (kind_q),
    .esc_i    (esc_q),
    .len_nz_i (len_q != '0),
    .step_o   (step)
  );

  assign line_ext = {16'h0000, line_q};
  assign line16   = line_ext[15:0];
  assign cfg_ext  = {{LINE_BITS{1'b0}}, cfg_wdata_i};

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  // output register frees when empty or drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // error and empty-token results go straight to the output register
  assign direct   = step.error || (step.close && !nb_seen_q);

  // a register write takes the cycle, the byte waits
  assign in_stall_o = (state_q != ST_IDLE) || cfg_wr || (direct && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // readout pipeline: memory data moves on when the output register takes it
  assign out_load = dat_vld_q && out_free;
  assign rd_en    = (state_q == ST_EMIT) && rd_more_q && (!dat_vld_q || out_load);
  assign rd_last  = (rd_ptr_q + LEN_ONE) == end_q;
  assign wr_en    = in_acc && step.append && (len_q < LEN_MAX);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    esc_d       = esc_q;
    line_d      = line_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    nb_seen_d   = nb_seen_q;
    first_d     = first_q;
    hi_d        = hi_q;
    rd_ptr_d    = rd_ptr_q;
    end_d       = end_q;
    rd_more_d   = rd_more_q;
    dat_vld_d   = dat_vld_q;
    dat_last_d  = dat_last_q;
    emit_kind_d = emit_kind_q;
    emit_line_d = emit_line_q;
    emit_ovf_d  = emit_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_event_d = out_event_q;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_line_d  = out_line_q;
    out_code_d  = out_code_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;

    if (cfg_wr) begin
      line_d = cfg_ext[LINE_BITS-1:0];
    end

    if (in_acc) begin
      kind_d = step.kind_next;
      esc_d  = step.esc_next;
      if (step.line_inc) begin
        line_d = line_q + LINE_BITS'(1);
      end
      // append with trim tracking, drop once full
      if (step.append) begin
        if (len_q < LEN_MAX) begin
          len_d = len_q + LEN_ONE;
          if (!is_blank(text_byte_i)) begin
            if (!nb_seen_q) begin
              first_d = len_q;
            end
            hi_d      = len_q + LEN_ONE;
            nb_seen_d = 1'b1;
          end
        end else begin
          ovf_d = 1'b1;
        end
      end
      if (step.error) begin
        out_valid_d = 1'b1;
        out_event_d = EV_ERROR;
        out_kind_d  = KIND_COMMAND;
        out_byte_d  = 8'h00;
        out_line_d  = line16;
        out_code_d  = step.err_code;
        out_ovf_d   = 1'b0;
        out_last_d  = 1'b1;
      end
      if (step.close) begin
        len_d     = '0;
        ovf_d     = 1'b0;
        nb_seen_d = 1'b0;
        if (nb_seen_q) begin
          // stream the trimmed span out of the store
          state_d     = ST_EMIT;
          rd_ptr_d    = first_q;
          end_d       = hi_q;
          rd_more_d   = 1'b1;
          emit_kind_d = step.close_kind;
          emit_line_d = line16;
          emit_ovf_d  = ovf_q;
        end else begin
          out_valid_d = 1'b1;
          out_event_d = EV_EMPTY;
          out_kind_d  = step.close_kind;
          out_byte_d  = 8'h00;
          out_line_d  = line16;
          out_code_d  = ERR_ESCAPE;
          out_ovf_d   = ovf_q;
          out_last_d  = 1'b1;
        end
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_event_d = EV_BYTE;
      out_kind_d  = emit_kind_q;
      out_byte_d  = rd_data_q;
      out_line_d  = emit_line_q;
      out_code_d  = ERR_ESCAPE;
      out_ovf_d   = emit_ovf_q;
      out_last_d  = dat_last_q;
      dat_vld_d   = 1'b0;
      if (dat_last_q) begin
        state_d = ST_IDLE;
      end
    end

    if (rd_en) begin
      rd_ptr_d   = rd_ptr_q + LEN_ONE;
      dat_vld_d  = 1'b1;
      dat_last_d = rd_last;
      if (rd_last) begin
        rd_more_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_UNSET;
      esc_q       <= 1'b0;
      line_q      <= LINE_BITS'(1);
      len_q       <= '0;
      ovf_q       <= 1'b0;
      nb_seen_q   <= 1'b0;
      rd_more_q   <= 1'b0;
      dat_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      esc_q       <= esc_d;
      line_q      <= line_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      nb_seen_q   <= nb_seen_d;
      rd_more_q   <= rd_more_d;
      dat_vld_q   <= dat_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    hi_q        <= hi_d;
    rd_ptr_q    <= rd_ptr_d;
    end_q       <= end_d;
    dat_last_q  <= dat_last_d;
    emit_kind_q <= emit_kind_d;
    emit_line_q <= emit_line_d;
    emit_ovf_q  <= emit_ovf_d;
    out_event_q <= out_event_d;
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_line_q  <= out_line_d;
    out_code_q  <= out_code_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  // token store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[AW-1:0]] <= text_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_ptr_q[AW-1:0]];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_event_q;
  assign token_kind_o    = out_kind_q;
  assign token_byte_o    = out_byte_q;
  assign line_number_o   = out_line_q;
  assign error_code_o    = out_code_q;
  assign overflowed_o    = out_ovf_q;
  assign last_of_token_o = out_last_q;

`ifndef SYNTHESIS
  // readout data only exists while a token is being streamed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dat_vld_q || rd_more_q) |-> (state_q == ST_EMIT))
    else $error("token readout active outside emit state");

  // read pointer stays inside the trimmed span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_more_q |-> (rd_ptr_q < end_q) && (end_q <= LEN_MAX))
    else $error("read pointer past token end");

  // trim bounds stay within the filled part of the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nb_seen_q |-> (first_q < hi_q) && (hi_q <= len_q) && (len_q <= LEN_MAX))
    else $error("trim bounds inconsistent with token length");

  // no new byte is taken while a token streams out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> !(in_acc && $past(dat_vld_q && !dat_last_q)))
    else $error("byte accepted during token readout");
`endif

endmodule

/* tb/build_script_tokenizer_tb.sv */
// self-checking testbench of the build script tokenizer: random script text, per-field checks
module build_script_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam int TOK_DEPTH   = 64;
  localparam int HOLD_CYCLES = 400;
  // worst case is every byte closing a full token under heavy output stall; this is far above
  localparam int unsigned CYCLE_LIMIT = 800_000;
  // error code and token kind fields read as zero where they carry no meaning
  localparam logic [2:0] NO_CODE = 3'd0;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [2:0]  token_kind;
    logic [7:0]  token_byte;
    logic [15:0] line_number;
    logic [2:0]  error_code;
    logic        overflowed;
    logic        last_of_token;
  } lex_event_t;

  // dut ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_kind_o;
  logic [2:0]  token_kind_o;
  logic [7:0]  token_byte_o;
  logic [15:0] line_number_o;
  logic [2:0]  error_code_o;
  logic        overflowed_o;
  logic        last_of_token_o;

  // script bytes waiting to be sent, and events the lexer must still produce
  logic [7:0] script_q [$];
  lex_event_t lexer_events [$];

  // request bookkeeping between the sampling process and the byte driver
  int unsigned in_acc_cnt   = 0;
  int unsigned in_offer_cnt = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;

  // idling knobs, written only by the sequencer, and the hold-off count of the result sink
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_go        = 1'b0;
  int unsigned hold_cnt       = 0;

  // mirror of the lexer state, starts as after reset
  logic [2:0]  lex_kind = KIND_UNSET;
  logic        lex_esc  = 1'b0;
  logic [15:0] lex_line = 16'd1;
  logic [7:0]  tok_buf [TOK_DEPTH];
  int          tok_len  = 0;
  logic        tok_ovf  = 1'b0;

  build_script_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .token_kind_o   (token_kind_o),
    .token_byte_o   (token_byte_o),
    .line_number_o  (line_number_o),
    .error_code_o   (error_code_o),
    .overflowed_o   (overflowed_o),
    .last_of_token_o(last_of_token_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // lexer prediction
  // ---------------------------------------------------------------------------

  task automatic emit(logic [1:0] ev, logic [2:0] kind, logic [7:0] b, logic [2:0] code,
                      logic ovf);
    lex_event_t e;
    e.event_kind    = ev;
    e.token_kind    = kind;
    e.token_byte    = b;
    e.line_number   = lex_line;
    e.error_code    = code;
    e.overflowed    = ovf;
    e.last_of_token = 1'b0;
    lexer_events.insert(lexer_events.size(), e);
  endtask

  // bytes past the buffer are dropped, the token remembers it
  task automatic store_byte(logic [7:0] c);
    if (tok_len < TOK_DEPTH) begin
      tok_buf[tok_len] = c;
      tok_len++;
    end else begin
      tok_ovf = 1'b1;
    end
  endtask

  task automatic raise_syntax(logic [2:0] code);
    emit(EV_ERROR, KIND_COMMAND, 8'h00, code, 1'b0);
  endtask

  // trim blanks on both ends, then one event per byte or a single empty event
  task automatic close_token();
    logic [2:0] k;
    int lo;
    int hi;
    k  = (lex_kind == KIND_UNSET) ? KIND_COMMAND : lex_kind;
    lo = 0;
    hi = tok_len;
    while (lo < hi && (tok_buf[lo] == CH_SPACE || tok_buf[lo] == CH_TAB)) lo++;
    while (hi > lo && (tok_buf[hi-1] == CH_SPACE || tok_buf[hi-1] == CH_TAB)) hi--;
    if (lo == hi) begin
      emit(EV_EMPTY, k, 8'h00, NO_CODE, tok_ovf);
    end else begin
      for (int i = lo; i < hi; i++) emit(EV_BYTE, k, tok_buf[i], NO_CODE, tok_ovf);
    end
    lex_kind = KIND_UNSET;
    tok_len  = 0;
    tok_ovf  = 1'b0;
  endtask

  task automatic lex_byte(logic [7:0] c);
    logic       in_text;
    int         before_n;
    lex_event_t tail;
    in_text  = (lex_kind == KIND_STRING) || (lex_kind == KIND_COMMENT);
    before_n = lexer_events.size();
    case (c)
      CH_BSLASH: begin
        if (!lex_esc) begin
          lex_esc = 1'b1;
        end else if (lex_kind != KIND_UNSET) begin
          store_byte(c);
          lex_esc = 1'b0;
        end else begin
          // escaped backslash with no kind: error, flag stays set
          raise_syntax(ERR_ESCAPE);
        end
      end
      CH_HASH: begin
        if (!lex_esc && lex_kind == KIND_UNSET) begin
          if (tok_len != 0) close_token();
          lex_kind = KIND_COMMENT;
        end else if (in_text) begin
          lex_esc = 1'b0;
          store_byte(c);
        end else begin
          lex_esc = 1'b0;
          raise_syntax(ERR_HASH);
        end
      end
      CH_QUOTE: begin
        if (lex_kind == KIND_UNSET) begin
          if (!lex_esc) lex_kind = KIND_STRING;
          else raise_syntax(ERR_ESCAPE);
        end else if (lex_kind == KIND_STRING) begin
          if (lex_esc) begin
            store_byte(c);
            lex_esc = 1'b0;
          end else begin
            close_token();
          end
        end
        // a quote inside any other kind is ignored
      end
      CH_EQUALS, CH_COLON: begin
        if (lex_kind == KIND_UNSET) begin
          if (lex_esc) begin
            raise_syntax(ERR_ESCAPE);
            lex_esc = 1'b0;
          end else begin
            lex_kind = (c == CH_EQUALS) ? KIND_VARIABLE : KIND_FUNCTION;
            close_token();
          end
        end else if (in_text) begin
          store_byte(c);
        end else begin
          raise_syntax((c == CH_EQUALS) ? ERR_EQUALS : ERR_COLON);
        end
      end
      CH_BANG: begin
        if (in_text) store_byte(c);
        else if (lex_kind != KIND_UNSET) raise_syntax(ERR_BANG);
        else lex_kind = KIND_CALL;
      end
      CH_SPACE, CH_TAB: begin
        if (!in_text && lex_kind != KIND_UNSET) close_token();
        else store_byte(c);
      end
      CH_NL: begin
        // escaped newline continues the token but still counts the line
        if (lex_esc) lex_esc = 1'b0;
        else close_token();
        lex_line = lex_line + 16'd1;
      end
      default: store_byte(c);
    endcase
    if (lexer_events.size() > before_n) begin
      tail = lexer_events.pop_back();
      tail.last_of_token = 1'b1;
      lexer_events.insert(lexer_events.size(), tail);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sampling at the rising edge: config writes, accepted bytes, results
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : lexer_scoreboard
    lex_event_t got;
    lex_event_t want;
    if (rst_ni) begin
      // a register write reloads the line counter
      if (cfg_valid_i && cfg_ready_o) lex_line = cfg_wdata_i;
      // predict before checking so a same-cycle result would still find its entry
      if (in_valid_i && !in_stall_o) begin
        lex_byte(text_byte_i);
        in_acc_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {event_kind_o, token_kind_o, token_byte_o, line_number_o, error_code_o,
               overflowed_o, last_of_token_o};
        if (lexer_events.size() == 0) begin
          $error("result with nothing expected: event %0d byte %0h line %0d",
                 event_kind_o, token_byte_o, line_number_o);
          fail_cnt++;
        end else begin
          want = lexer_events.pop_front();
          check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
          check_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
          check_field("token_byte", 32'(want.token_byte), 32'(got.token_byte));
          check_field("line_number", 32'(want.line_number), 32'(got.line_number));
          check_field("error_code", 32'(want.error_code), 32'(got.error_code));
          check_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
          check_field("last_of_token", 32'(want.last_of_token), 32'(got.last_of_token));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte driver: a new request only once the previous one was taken,
  // so valid never looks at stall and a stalled byte holds still
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : byte_driver
    if (in_acc_cnt == in_offer_cnt) begin
      if (script_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        text_byte_i <= script_q.pop_front();
        in_valid_i  <= 1'b1;
        in_offer_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink: random stall, plus one long hold-off counted here
  always @(negedge clk_i) begin : result_sink
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_cnt++;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[build_script_tokenizer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // script text generation
  // ---------------------------------------------------------------------------

  function automatic logic is_special(logic [7:0] c);
    return c inside {CH_BSLASH, CH_HASH, CH_QUOTE, CH_EQUALS, CH_COLON, CH_BANG,
                     CH_SPACE, CH_TAB, CH_NL};
  endfunction

  // ordinary text byte, now and then from the full byte range
  function automatic logic [7:0] plain_ch();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 15) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(33, 126));
    end while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] special_ch();
    case ($urandom_range(0, 8))
      0: return CH_BSLASH;
      1: return CH_HASH;
      2: return CH_QUOTE;
      3: return CH_EQUALS;
      4: return CH_COLON;
      5: return CH_BANG;
      6: return CH_SPACE;
      7: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  task automatic put(logic [7:0] c);
    script_q.insert(script_q.size(), c);
  endtask

  task automatic put_word(int n);
    repeat (n) put(plain_ch());
  endtask

  task automatic put_blanks(int n);
    repeat ($urandom_range(0, n)) put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  // a line that can run past the token buffer
  task automatic put_long_line();
    put_blanks(2);
    put_word($urandom_range(60, 75));
    put_blanks(2);
    put(CH_NL);
  endtask

  // mostly well-formed statements, some broken ones and raw noise
  task automatic put_statement();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      // variable assignment
      put_blanks(3); put_word($urandom_range(1, 8)); put_blanks(2); put(CH_EQUALS);
      put_blanks(2); put_word($urandom_range(1, 10)); put_blanks(3); put(CH_NL);
    end else if (sel < 27) begin
      // function definition
      put_blanks(2); put_word($urandom_range(1, 8)); put(CH_COLON);
      put_blanks(2); put_word($urandom_range(0, 10)); put(CH_NL);
    end else if (sel < 39) begin
      // call with arguments
      put_blanks(1); put(CH_BANG); put_word($urandom_range(1, 8));
      repeat ($urandom_range(0, 3)) begin
        put(CH_SPACE); put_word($urandom_range(1, 6));
      end
      put(CH_NL);
    end else if (sel < 51) begin
      // string literal with escapes and steering bytes inside
      put_blanks(2); put(CH_QUOTE);
      repeat ($urandom_range(0, 14)) begin
        case ($urandom_range(0, 9))
          6: begin put(CH_BSLASH); put(CH_QUOTE); end
          7: begin put(CH_BSLASH); put(CH_BSLASH); end
          8: put($urandom_range(0, 1) ? CH_EQUALS : ($urandom_range(0, 1) ? CH_COLON : CH_BANG));
          9: put(CH_SPACE);
          default: put(plain_ch());
        endcase
      end
      put(CH_QUOTE);
      if ($urandom_range(0, 1)) put(CH_NL);
    end else if (sel < 61) begin
      // comment holding anything but newline
      put_blanks(1); put(CH_HASH);
      repeat ($urandom_range(0, 14)) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: put(CH_EQUALS);
            1: put(CH_COLON);
            2: put(CH_BANG);
            3: put(CH_HASH);
            default: put(CH_QUOTE);
          endcase
        end else begin
          put(plain_ch());
        end
      end
      put(CH_NL);
    end else if (sel < 66) begin
      // continued line
      put_word($urandom_range(1, 5)); put(CH_BSLASH); put(CH_NL);
      put_word($urandom_range(1, 5)); put(CH_NL);
    end else if (sel < 71) begin
      put_blanks(4); put(CH_NL);
    end else if (sel < 74) begin
      put_long_line();
    end else if (sel < 88) begin
      // rule violations
      case ($urandom_range(0, 8))
        0: begin put(CH_BANG); put_word(2); put(CH_EQUALS); end
        1: begin put(CH_BANG); put_word(2); put(CH_COLON); end
        2: begin put(CH_BANG); put(CH_BANG); end
        3: begin put(CH_BANG); put_word(1); put(CH_HASH); end
        4: begin put(CH_BSLASH); put(CH_BSLASH); end
        5: begin put(CH_BSLASH); put(CH_QUOTE); end
        6: begin put(CH_BSLASH); put(CH_EQUALS); end
        7: begin put(CH_BSLASH); put(CH_COLON); end
        default: begin put(CH_BSLASH); put(CH_HASH); end
      endcase
      put(CH_NL);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) put(special_ch());
        else put(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // sender holds back until every byte is taken and every result has arrived
  task automatic wait_drained();
    while (script_q.size() != 0 || in_acc_cnt != in_offer_cnt || lexer_events.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_first_line(logic [15:0] value);
    wait_drained();
    // a byte with no result may still be in the pipe
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : sequencer
    logic [15:0] base;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset line number, extreme bytes, every rule and error code
    put(CH_TAB); put(8'h00); put(8'hFF); put(CH_NL);            // leading blank trimmed
    put(CH_BANG); put("f"); put(CH_EQUALS); put(CH_COLON);      // bad equals, bad colon
    put(CH_BANG); put(CH_HASH); put(CH_QUOTE); put(CH_SPACE);   // bad bang, bad hash, quote ignored
    put(CH_BSLASH); put(CH_BSLASH); put(CH_QUOTE); put(CH_EQUALS); // escape errors
    put(CH_BSLASH); put(CH_NL);                                 // continuation
    put("a"); put(CH_HASH); put("c"); put(CH_NL);               // token closed by hash, comment
    put(CH_QUOTE); put("q"); put(CH_QUOTE);                     // string literal
    put(CH_NL);                                                 // empty command
    wait_drained();

    // no idling, line counter from zero, one long line that can overflow
    write_first_line(16'h0000);
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    put_long_line();
    while (script_q.size() < 110) put_statement();
    wait_drained();

    // sender mostly idle, line counter wraps past the top
    write_first_line(16'hFFFF);
    send_idle_pct  = 71;
    sink_stall_pct = 0;
    while (script_q.size() < 110) put_statement();
    wait_drained();

    // receiver mostly stalled, and one long hold-off with the sender flat out
    base = 16'($urandom_range(2, 65534));
    write_first_line(base);
    send_idle_pct  = 0;
    sink_stall_pct = 71;
    while (script_q.size() < 110) put_statement();
    hold_go = 1'b1;
    wait_drained();

    // light idling on both sides, back to the reset line number
    write_first_line(16'h0001);
    send_idle_pct  = 10;
    sink_stall_pct = 10;
    while (script_q.size() < 110) put_statement();
    wait_drained();

    // let any stray result show up
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[build_script_tokenizer] OK");
    end else begin
      $display("[build_script_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
